FILE: sv/lfp_pkg.sv
// Shared types, constants and the brake level function for the lidar frame parser.
package lfp_pkg;

    // Field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned DIST_W  = 16;
    localparam int unsigned LEVEL_W = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Frame header byte ('Y') and the sum of the two headers
    localparam logic [BYTE_W-1:0] HDR_BYTE = 8'h59;
    localparam logic [BYTE_W-1:0] HDR_SUM  = 8'(HDR_BYTE + HDR_BYTE);

    // Threshold reset values
    localparam logic [DIST_W-1:0] FAR_THR_RST    = 16'd200;
    localparam logic [DIST_W-1:0] CLOSE_THR_RST  = 16'd100;
    localparam logic [DIST_W-1:0] DANGER_THR_RST = 16'd60;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DANGER = 2'd2;

    // Brake level codes
    localparam logic [LEVEL_W-1:0] LVL_NONE   = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_FAR    = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_CLOSE  = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_VCLOSE = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_DANGER = 3'd4;

    typedef struct packed {
        logic [DIST_W-1:0] far_thr;
        logic [DIST_W-1:0] close_thr;
        logic [DIST_W-1:0] danger_thr;
    } t_thresh;

    typedef struct packed {
        logic [DIST_W-1:0]  distance_cm;
        logic [LEVEL_W-1:0] brake_level;
        logic               frame_good;
    } t_beat;

    typedef struct packed {
        logic  valid;
        t_beat beat;
    } t_result;

    // Strict priority chain: far, then close, then very close, else danger
    function automatic logic [LEVEL_W-1:0] level_of(input logic [DIST_W-1:0] d,
                                                     input t_thresh thr);
        logic [LEVEL_W-1:0] lvl;
        if (d > thr.far_thr) begin
            lvl = LVL_FAR;
        end else if (d > thr.close_thr) begin
            lvl = LVL_CLOSE;
        end else if (d > thr.danger_thr) begin
            lvl = LVL_VCLOSE;
        end else begin
            lvl = LVL_DANGER;
        end
        return lvl;
    endfunction

endpackage

FILE: sv/lfp_in_if.sv
// Input byte channel: valid/ready with one received byte per beat.
interface lfp_in_if;
    logic                        valid;
    logic                        ready;
    logic [lfp_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: sv/lfp_out_if.sv
// Result channel: valid/ready with distance, brake level and checksum flag.
interface lfp_out_if;
    logic                         valid;
    logic                         ready;
    logic [lfp_pkg::DIST_W-1:0]   distance_cm;
    logic [lfp_pkg::LEVEL_W-1:0]  brake_level;
    logic                         frame_good;

    modport source (output valid, output distance_cm, output brake_level,
                    output frame_good, input ready);
    modport sink   (input valid, input distance_cm, input brake_level,
                    input frame_good, output ready);
endinterface

FILE: sv/lfp_parser.sv
// Frame sync state machine, checksum accumulation and brake level decision.
module lfp_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_beat,
    input  logic [lfp_pkg::BYTE_W-1:0]  i_byte,
    input  lfp_pkg::t_thresh            i_thr,
    output lfp_pkg::t_result            o_res
);

    typedef enum logic [3:0] {
        PH_HUNT = 4'd0,
        PH_HDR2 = 4'd1,
        PH_DLO  = 4'd2,
        PH_DHI  = 4'd3,
        PH_SLO  = 4'd4,
        PH_SHI  = 4'd5,
        PH_RSV  = 4'd6,
        PH_QUAL = 4'd7,
        PH_CHK  = 4'd8
    } t_phase;

    t_phase                          r_phase, n_phase;
    logic [lfp_pkg::BYTE_W-1:0]      r_dlo, n_dlo;
    logic [lfp_pkg::BYTE_W-1:0]      r_dhi, n_dhi;
    logic [lfp_pkg::BYTE_W-1:0]      r_sum, n_sum;
    logic [lfp_pkg::LEVEL_W-1:0]     r_last_lvl, n_last_lvl;

    logic [lfp_pkg::DIST_W-1:0]      dist_cm;
    logic [lfp_pkg::LEVEL_W-1:0]     new_lvl;
    logic                            sum_ok;

    assign dist_cm = {r_dhi, r_dlo};
    assign new_lvl = lfp_pkg::level_of(dist_cm, i_thr);
    assign sum_ok  = (r_sum == i_byte);

    // Next state and result for the byte on this beat
    always_comb begin
        n_phase    = r_phase;
        n_dlo      = r_dlo;
        n_dhi      = r_dhi;
        n_sum      = r_sum;
        n_last_lvl = r_last_lvl;
        o_res.valid            = 1'b0;
        o_res.beat.distance_cm = dist_cm;
        o_res.beat.frame_good  = sum_ok;
        o_res.beat.brake_level = sum_ok ? new_lvl : r_last_lvl;
        if (i_beat) begin
            case (r_phase)
                PH_HDR2: begin
                    if (i_byte == lfp_pkg::HDR_BYTE) begin
                        n_sum   = lfp_pkg::HDR_SUM;
                        n_phase = PH_DLO;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_DLO, PH_DHI, PH_SLO, PH_SHI, PH_RSV, PH_QUAL: begin
                    if (r_phase == PH_DLO) n_dlo = i_byte;
                    if (r_phase == PH_DHI) n_dhi = i_byte;
                    n_sum   = r_sum + i_byte;
                    n_phase = t_phase'(r_phase + 4'd1);
                end
                PH_CHK: begin
                    o_res.valid = 1'b1;
                    if (sum_ok) n_last_lvl = new_lvl;
                    n_phase = PH_HUNT;
                end
                default: begin
                    // hunting, also recovers from any stray phase code
                    n_phase = (i_byte == lfp_pkg::HDR_BYTE) ? PH_HDR2 : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_dlo      <= '0;
            r_dhi      <= '0;
            r_sum      <= '0;
            r_last_lvl <= lfp_pkg::LVL_NONE;
        end else begin
            r_phase    <= n_phase;
            r_dlo      <= n_dlo;
            r_dhi      <= n_dhi;
            r_sum      <= n_sum;
            r_last_lvl <= n_last_lvl;
        end
    end

endmodule

FILE: sv/lidar_frame_parse_brake_level.sv
// Top level: lidar frame parser with threshold registers and output skid stage.
//
// Usage:
//   i_in carries one received link byte per beat (valid/ready). The parser
//   hunts for two 0x59 header bytes, collects six data bytes and checks
//   the 8-bit additive checksum. On the checksum byte one result beat goes
//   out on o_out: distance_cm, frame_good and brake_level (1 far .. 4 danger;
//   on a bad checksum the last good level, 0 before any good frame).
//   The user writes thresholds via i_cfg_we / i_cfg_idx / i_cfg_data (0 far,
//   1 close, 2 danger; 3 ignored) only while the block is idle; not enforced.
// Timing:
//   One byte per cycle while i_in.ready is high. The result beat is registered
//   and held in the output register, or in the skid register if o_out stalls.
// Reset (synchronous, active low):
//   Sync returns to header hunt, last level to 0, thresholds to 200/100/60,
//   output and skid registers empty.
// Stall:
//   While o_out is stalled a second result lands in the skid register; only
//   when that is full does i_in.ready drop, until the output drains.
module lidar_frame_parse_brake_level (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    lfp_in_if.sink                          i_in,
    lfp_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [lfp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lfp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    lfp_pkg::t_thresh  r_thr;
    lfp_pkg::t_result  parse_res;
    lfp_pkg::t_beat    r_out, r_skid;
    logic              r_out_valid, r_skid_valid;
    logic              in_beat, out_beat;

    assign i_in.ready = !r_skid_valid;
    assign in_beat    = i_in.valid && i_in.ready;
    assign out_beat   = r_out_valid && o_out.ready;

    // Threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.far_thr    <= lfp_pkg::FAR_THR_RST;
            r_thr.close_thr  <= lfp_pkg::CLOSE_THR_RST;
            r_thr.danger_thr <= lfp_pkg::DANGER_THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lfp_pkg::CFG_FAR:    r_thr.far_thr    <= i_cfg_data;
                lfp_pkg::CFG_CLOSE:  r_thr.close_thr  <= i_cfg_data;
                lfp_pkg::CFG_DANGER: r_thr.danger_thr <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    lfp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (in_beat),
        .i_byte  (i_in.rx_byte),
        .i_thr   (r_thr),
        .o_res   (parse_res)
    );

    // Output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_beat) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (parse_res.valid) begin
            if (!r_out_valid || out_beat) begin
                r_out       <= parse_res.beat;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= parse_res.beat;
                r_skid_valid <= 1'b1;
            end
        end else if (out_beat) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.distance_cm = r_out.distance_cm;
    assign o_out.brake_level = r_out.brake_level;
    assign o_out.frame_good  = r_out.frame_good;

endmodule

FILE: sv/lfp_checker.sv
// Port-level checks for the lidar frame parser, bound to the top level.
module lfp_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_ready,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [lfp_pkg::DIST_W-1:0]      i_out_distance_cm,
    input  logic [lfp_pkg::LEVEL_W-1:0]     i_out_brake_level,
    input  logic                            i_out_frame_good
);

    // Output empty right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat valid after reset");

    // Level code stays within its range
    a_lvl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_brake_level <= lfp_pkg::LVL_DANGER))
        else $error("brake level out of range");

    // A good frame always carries a real level
    a_good_lvl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_frame_good) |-> (i_out_brake_level != lfp_pkg::LVL_NONE))
        else $error("good frame with no brake level");

    // Input only backs up when a result is waiting at the output
    a_bp_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && $past(i_out_valid) && !$past(i_out_ready)))
        else $error("input stalled without output stall");

    // Stalled result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_distance_cm) && $stable(i_out_brake_level)
             && $stable(i_out_frame_good)))
        else $error("stalled result beat changed");

endmodule

bind lidar_frame_parse_brake_level lfp_checker u_lfp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_distance_cm (o_out.distance_cm),
    .i_out_brake_level (o_out.brake_level),
    .i_out_frame_good  (o_out.frame_good)
);

FILE: tb/tb.sv
// Testbench for the lidar frame parser: byte stimulus, frame predictor and result scoreboard.
`timescale 1ns / 100ps

module tb;

    // Run sizing
    localparam int unsigned RX_BYTES    = 1300;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DUT_LAT     = 1;
    localparam int unsigned LONG_HOLD   = 80;

    // Index past the three thresholds; the block ignores it
    localparam logic [lfp_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Parse phases of the predictor
    localparam int unsigned PH_HUNT = 0;
    localparam int unsigned PH_HDR2 = 1;
    localparam int unsigned PH_DLO  = 2;
    localparam int unsigned PH_DHI  = 3;
    localparam int unsigned PH_CSUM = 8;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [lfp_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [lfp_pkg::CFG_DATA_W-1:0] i_cfg_data;

    lfp_in_if  in_if ();
    lfp_out_if out_if ();

    lidar_frame_parse_brake_level i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state
    lfp_pkg::t_thresh            thr_m;
    int unsigned                 phase_m;
    logic [lfp_pkg::BYTE_W-1:0]  dlo_m;
    logic [lfp_pkg::BYTE_W-1:0]  dhi_m;
    logic [lfp_pkg::BYTE_W-1:0]  sum_m;
    logic [lfp_pkg::LEVEL_W-1:0] held_lvl_m;
    lfp_pkg::t_beat              frame_q[$];

    // Run control and statistics
    bit          idle_on = 1'b1;
    int unsigned rx_hold = 0;
    int unsigned n_bytes = 0;
    int unsigned n_frame_bytes = 0;
    int unsigned n_good = 0;
    int unsigned n_bad = 0;
    int unsigned n_errors = 0;
    int unsigned n_cycles = 0;

    // Watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles, %0d results pending",
                     $time, n_cycles, frame_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Brake level as a strict priority chain over the thresholds
    function automatic logic [lfp_pkg::LEVEL_W-1:0] brake_for(
        input logic [lfp_pkg::DIST_W-1:0] d);
        logic [lfp_pkg::LEVEL_W-1:0] lvl;
        if (d > thr_m.far_thr) begin
            lvl = lfp_pkg::LVL_FAR;
        end else if (d > thr_m.close_thr) begin
            lvl = lfp_pkg::LVL_CLOSE;
        end else if (d > thr_m.danger_thr) begin
            lvl = lfp_pkg::LVL_VCLOSE;
        end else begin
            lvl = lfp_pkg::LVL_DANGER;
        end
        return lvl;
    endfunction

    // Advance the frame predictor by one accepted byte
    function automatic void predict_byte(input logic [lfp_pkg::BYTE_W-1:0] b);
        lfp_pkg::t_beat res;
        if (phase_m == PH_HDR2) begin
            if (b == lfp_pkg::HDR_BYTE) begin
                sum_m   = lfp_pkg::HDR_SUM;
                phase_m = PH_DLO;
            end else begin
                phase_m = PH_HUNT;
            end
        end else if (phase_m >= PH_DLO && phase_m < PH_CSUM) begin
            if (phase_m == PH_DLO) dlo_m = b;
            if (phase_m == PH_DHI) dhi_m = b;
            sum_m   = sum_m + b;
            phase_m = phase_m + 1;
        end else if (phase_m == PH_CSUM) begin
            res.distance_cm = {dhi_m, dlo_m};
            res.frame_good  = (sum_m == b);
            // bad checksum repeats the last good level
            if (res.frame_good) held_lvl_m = brake_for(res.distance_cm);
            res.brake_level = held_lvl_m;
            phase_m = PH_HUNT;
            frame_q.push_back(res);
        end else begin
            phase_m = (b == lfp_pkg::HDR_BYTE) ? PH_HDR2 : PH_HUNT;
        end
    endfunction

    // Offer one byte, after a random gap while idle_on is set, and wait for the beat
    task automatic send_byte(input logic [lfp_pkg::BYTE_W-1:0] b);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.rx_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_byte(b);
        n_bytes++;
    endtask

    // Whole frame: two headers, six data bytes, checksum (optionally corrupted)
    task automatic send_frame(input logic [lfp_pkg::DIST_W-1:0] dist_v, input bit good);
        logic [lfp_pkg::BYTE_W-1:0] body[6];
        logic [lfp_pkg::BYTE_W-1:0] csum;
        body[0] = dist_v[7:0];
        body[1] = dist_v[15:8];
        for (int i = 2; i < 6; i++) body[i] = 8'($urandom);
        csum = lfp_pkg::HDR_SUM;
        for (int i = 0; i < 6; i++) csum = csum + body[i];
        if (!good) csum = csum + 8'($urandom_range(1, 255));
        send_byte(lfp_pkg::HDR_BYTE);
        send_byte(lfp_pkg::HDR_BYTE);
        for (int i = 0; i < 6; i++) send_byte(body[i]);
        send_byte(csum);
        n_frame_bytes += 9;
    endtask

    // Stop offering, wait for every pending result, then let the pipe empty
    task automatic settle();
        in_if.valid <= 1'b0;
        while (frame_q.size() != 0) @(posedge i_clk);
        repeat (DUT_LAT + 3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [lfp_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [lfp_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            lfp_pkg::CFG_FAR:    thr_m.far_thr    = data;
            lfp_pkg::CFG_CLOSE:  thr_m.close_thr  = data;
            lfp_pkg::CFG_DANGER: thr_m.danger_thr = data;
            default: ;
        endcase
    endtask

    task automatic write_thresholds(input logic [lfp_pkg::DIST_W-1:0] far_v,
                                    input logic [lfp_pkg::DIST_W-1:0] close_v,
                                    input logic [lfp_pkg::DIST_W-1:0] danger_v);
        write_reg(lfp_pkg::CFG_FAR, far_v);
        write_reg(lfp_pkg::CFG_CLOSE, close_v);
        write_reg(lfp_pkg::CFG_DANGER, danger_v);
    endtask

    // Distances biased to the threshold boundaries and the range ends
    function automatic logic [lfp_pkg::DIST_W-1:0] pick_dist();
        logic [lfp_pkg::DIST_W-1:0] base;
        case ($urandom_range(0, 6))
            0:       base = thr_m.far_thr;
            1:       base = thr_m.close_thr;
            2:       base = thr_m.danger_thr;
            3:       base = 16'h0000;
            4:       base = 16'hFFFF;
            default: return 16'($urandom);
        endcase
        return base + 16'($urandom_range(0, 2)) - 16'd1;
    endfunction

    task automatic run_frames(input int unsigned n);
        repeat (n) send_frame(pick_dist(), $urandom_range(0, 5) != 0);
    endtask

    // Bad checksum before any good frame, stray header, then danger at zero distance
    task automatic test_directed();
        idle_on = 1'b1;
        send_frame(16'hFFFF, 1'b0);
        send_byte(lfp_pkg::HDR_BYTE);
        send_byte(8'h00);
        send_frame(16'h0000, 1'b1);
        settle();
    endtask

    // Reset values, both extremes, unordered set, spare index, ordinary set
    task automatic test_thresholds();
        idle_on = 1'b1;
        run_frames(10);
        settle();
        write_thresholds(16'h0000, 16'h0000, 16'h0000);
        run_frames(10);
        settle();
        write_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_frames(10);
        settle();
        write_thresholds(16'd50, 16'd3000, 16'd40000);
        run_frames(10);
        settle();
        write_reg(CFG_SPARE, 16'($urandom));
        run_frames(10);
        settle();
        write_thresholds(16'd1000, 16'd500, 16'd250);
        run_frames(10);
        settle();
    endtask

    // Output held off while frames keep coming: block fills and stalls input
    task automatic test_backpressure();
        idle_on = 1'b0;
        rx_hold = LONG_HOLD;
        run_frames(6);
        settle();
        idle_on = 1'b1;
    endtask

    // Mostly well-formed frames, noise, broken headers, misalignment, threshold writes
    task automatic test_random();
        while (n_frame_bytes < RX_BYTES) begin
            idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: begin
                    send_frame(pick_dist(), $urandom_range(0, 4) != 0);
                end
                7: begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
                end
                8: begin
                    send_byte(lfp_pkg::HDR_BYTE);
                    send_byte(8'($urandom));
                end
                default: begin
                    // extra header shifts the frame by one byte
                    send_byte(lfp_pkg::HDR_BYTE);
                    send_frame(pick_dist(), 1'b1);
                end
            endcase
            if ($urandom_range(0, 39) == 0) begin
                settle();
                write_thresholds(16'($urandom), 16'($urandom), 16'($urandom));
            end
        end
        settle();
    endtask

    // Result sink: random ready pattern, long hold on request, scoreboard
    initial begin : result_sink
        int unsigned    wait_cnt;
        lfp_pkg::t_beat want;
        wait_cnt = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) begin
                if (frame_q.size() == 0) begin
                    n_errors++;
                    $display("%0t unexpected result: expected none, actual %0d %0d %0b",
                             $time, out_if.distance_cm, out_if.brake_level,
                             out_if.frame_good);
                end else begin
                    want = frame_q.pop_front();
                    if (out_if.distance_cm !== want.distance_cm) begin
                        n_errors++;
                        $display("%0t distance_cm mismatch: expected %0d, actual %0d",
                                 $time, want.distance_cm, out_if.distance_cm);
                    end
                    if (out_if.brake_level !== want.brake_level) begin
                        n_errors++;
                        $display("%0t brake_level mismatch: expected %0d, actual %0d",
                                 $time, want.brake_level, out_if.brake_level);
                    end
                    if (out_if.frame_good !== want.frame_good) begin
                        n_errors++;
                        $display("%0t frame_good mismatch: expected %0b, actual %0b",
                                 $time, want.frame_good, out_if.frame_good);
                    end
                    if (want.frame_good) n_good++;
                    else n_bad++;
                end
                wait_cnt = idle_on ? $urandom_range(0, 6) : 0;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                out_if.ready <= 1'b0;
            end else if (wait_cnt > 0) begin
                wait_cnt--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Main sequence
    initial begin : stimulus
        int unsigned drain;
        in_if.valid   <= 1'b0;
        in_if.rx_byte <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        thr_m      = '{far_thr: lfp_pkg::FAR_THR_RST, close_thr: lfp_pkg::CLOSE_THR_RST,
                       danger_thr: lfp_pkg::DANGER_THR_RST};
        phase_m    = PH_HUNT;
        dlo_m      = '0;
        dhi_m      = '0;
        sum_m      = '0;
        held_lvl_m = lfp_pkg::LVL_NONE;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_thresholds();
        test_backpressure();
        test_random();

        // final drain with a bound, then the block's latency
        in_if.valid <= 1'b0;
        drain = 0;
        while (frame_q.size() != 0 && drain < 1000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (DUT_LAT + 4) @(posedge i_clk);
        if (frame_q.size() != 0) begin
            n_errors++;
            $display("%0t missing results: expected %0d more, actual 0",
                     $time, frame_q.size());
        end

        $display("Covered %0d bytes (%0d in frames), %0d good and %0d bad-checksum results",
                 n_bytes, n_frame_bytes, n_good, n_bad);
        $display("Threshold extremes, unordered set, spare index, output stall; %0d errors",
                 n_errors);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
